FILE: design/lds_pkg.sv
// Shared types, step codes and the microcode table for the LED driver serial shifter.
package lds_pkg;

    localparam int STEP_BITS = 3;
    localparam int CNT_BITS  = 5;
    localparam logic [CNT_BITS-1:0] MAX_PULSES = 5'd16;

    typedef logic [STEP_BITS-1:0] step_t;

    localparam step_t STEP_FETCH       = 3'd0;
    localparam step_t STEP_INSTR_CHECK = 3'd1;
    localparam step_t STEP_INSTR_EMIT  = 3'd2;
    localparam step_t STEP_SHIFT_CHECK = 3'd3;
    localparam step_t STEP_SHIFT_EMIT  = 3'd4;

    typedef enum logic [1:0] {
        COND_FUNC_SET,
        COND_LATCH_ZERO,
        COND_NO_SHIFT,
        COND_LAST_PULSE
    } cond_t;

    // One microcode word
    typedef struct packed {
        logic  accept;      // wait for and take an input item
        logic  emit;        // wait for the output register and load one pulse
        logic  shift_mode;  // data from the shift register, else held level
        logic  clr_cnt;     // clear the pulse counter
        cond_t cond;        // jump condition
        step_t jump;        // target when the condition holds
        step_t next;        // target otherwise
    } ctrl_t;

    // Condition inputs from the datapath
    typedef struct packed {
        logic func;
        logic latch_zero;
        logic no_shift;
        logic last_pulse;
    } seq_flags_t;

    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        unique case (step)
            STEP_FETCH:
                w = '{accept: 1'b1, emit: 1'b0, shift_mode: 1'b0, clr_cnt: 1'b0,
                      cond: COND_FUNC_SET, jump: STEP_SHIFT_CHECK,
                      next: STEP_INSTR_CHECK};
            STEP_INSTR_CHECK:
                w = '{accept: 1'b0, emit: 1'b0, shift_mode: 1'b0, clr_cnt: 1'b1,
                      cond: COND_LATCH_ZERO, jump: STEP_FETCH,
                      next: STEP_INSTR_EMIT};
            STEP_INSTR_EMIT:
                w = '{accept: 1'b0, emit: 1'b1, shift_mode: 1'b0, clr_cnt: 1'b0,
                      cond: COND_LAST_PULSE, jump: STEP_FETCH,
                      next: STEP_INSTR_EMIT};
            STEP_SHIFT_CHECK:
                w = '{accept: 1'b0, emit: 1'b0, shift_mode: 1'b1, clr_cnt: 1'b1,
                      cond: COND_NO_SHIFT, jump: STEP_FETCH,
                      next: STEP_SHIFT_EMIT};
            STEP_SHIFT_EMIT:
                w = '{accept: 1'b0, emit: 1'b1, shift_mode: 1'b1, clr_cnt: 1'b0,
                      cond: COND_LAST_PULSE, jump: STEP_FETCH,
                      next: STEP_SHIFT_EMIT};
            default:
                w = '{accept: 1'b0, emit: 1'b0, shift_mode: 1'b0, clr_cnt: 1'b0,
                      cond: COND_FUNC_SET, jump: STEP_FETCH, next: STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

FILE: design/lds_seq.sv
// Microcode sequencer: step counter, control table lookup and conditional jumps.
module lds_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  lds_pkg::seq_flags_t flags,
    output lds_pkg::ctrl_t      ctrl
);
    import lds_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  cond_true;

    assign ctrl = ucode_rom(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_FUNC_SET:   cond_true = flags.func;
            COND_LATCH_ZERO: cond_true = flags.latch_zero;
            COND_NO_SHIFT:   cond_true = flags.no_shift;
            COND_LAST_PULSE: cond_true = flags.last_pulse;
            default:         cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (advance)
        begin
            step_next = cond_true ? ctrl.jump : ctrl.next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: design/led_driver_serial_shifter.sv
// Top level: serializes LED driver commands into data/latch-enable pulses.
//
//  channel | dir | bus fields
//  --------+-----+----------------------------------------------------------
//  s_*     | in  | tuser: func; tdata: data_word, shift_count, latch_count
//  m_*     | out | tdata: sdi_bit, latch_enable; tlast: last
//
// A command passes through a fetch step and a check step and then one emit
// step per pulse; the emit step of the microcode sets the pace.
// rst_n clears the step counter and output valid and drives the held data
// level high. A stalled output register holds the emit step in place.
module led_driver_serial_shifter #(
    parameter int WORD_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // [0] func
    input  logic [31:0] s_tdata,   // [15:0] data_word, [20:16] shift_count,
                                   // [25:21] latch_count, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] sdi_bit, [1] latch_enable, rest zero
    output logic        m_tlast    // last
);
    import lds_pkg::*;

    localparam int EXT_WIDTH = WORD_WIDTH + 16;

    ctrl_t      ctrl;
    seq_flags_t flags;
    logic       advance;
    logic       out_free;
    logic       in_fire;
    logic       emit_fire;

    logic [WORD_WIDTH-1:0] shreg_reg, shreg_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]   shift_cnt_reg, latch_cnt_reg;
    logic [CNT_BITS-1:0]   shift_sat, latch_sat;
    logic [CNT_BITS-1:0]   limit;
    logic [CNT_BITS-1:0]   cnt_inc;
    logic [CNT_BITS-1:0]   le_start;
    logic [EXT_WIDTH-1:0]  word_ext;
    logic                  sdi_level_reg, sdi_level_next;
    logic                  pulse_sdi, pulse_le;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [1:0] pulse_reg;
    logic       m_tlast_reg;

    function automatic logic [CNT_BITS-1:0] sat_count(input logic [CNT_BITS-1:0] v);
        return (v > MAX_PULSES) ? MAX_PULSES : v;
    endfunction

    lds_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    assign out_free  = !m_tvalid_reg || m_tready;
    assign advance   = !((ctrl.accept && !s_tvalid) || (ctrl.emit && !out_free));
    assign s_tready  = ctrl.accept;
    assign in_fire   = s_tvalid && ctrl.accept;
    assign emit_fire = ctrl.emit && out_free;

    assign shift_sat = sat_count(s_tdata[20:16]);
    assign latch_sat = sat_count(s_tdata[25:21]);
    assign word_ext  = EXT_WIDTH'(s_tdata[15:0]);

    assign limit    = ctrl.shift_mode ? shift_cnt_reg : latch_cnt_reg;
    assign cnt_inc  = cnt_reg + 5'd1;
    assign le_start = shift_cnt_reg - latch_cnt_reg;

    assign flags.func       = s_tuser;
    assign flags.latch_zero = (latch_cnt_reg == '0);
    assign flags.no_shift   = (latch_cnt_reg >= shift_cnt_reg);
    assign flags.last_pulse = (cnt_inc == limit);

    assign pulse_sdi = ctrl.shift_mode ? shreg_reg[WORD_WIDTH-1] : sdi_level_reg;
    assign pulse_le  = ctrl.shift_mode ? (cnt_reg >= le_start) : 1'b1;

    always_comb
    begin
        shreg_next     = shreg_reg;
        cnt_next       = cnt_reg;
        sdi_level_next = sdi_level_reg;
        if (in_fire)
        begin
            shreg_next = word_ext[WORD_WIDTH-1:0];
        end
        if (ctrl.clr_cnt)
        begin
            cnt_next = '0;
        end
        if (emit_fire)
        begin
            cnt_next = cnt_inc;
            if (ctrl.shift_mode)
            begin
                // zeros enter from the bottom once the word runs out
                shreg_next     = {shreg_reg[WORD_WIDTH-2:0], 1'b0};
                sdi_level_next = shreg_reg[WORD_WIDTH-1];
            end
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (emit_fire)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg  <= 1'b0;
            sdi_level_reg <= 1'b1;
            cnt_reg       <= '0;
        end
        else
        begin
            m_tvalid_reg  <= m_tvalid_next;
            sdi_level_reg <= sdi_level_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shreg_reg <= shreg_next;
        if (in_fire)
        begin
            shift_cnt_reg <= shift_sat;
            latch_cnt_reg <= latch_sat;
        end
        if (emit_fire)
        begin
            pulse_reg   <= {pulse_le, pulse_sdi};
            m_tlast_reg <= flags.last_pulse;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, pulse_reg};
    assign m_tlast  = m_tlast_reg;

    // Taking a command always leaves the fetch step for one check step
    a_fetch_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("input accepted twice in a row");

    // The final pulse of a command returns the sequencer to fetch
    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && flags.last_pulse) |=> s_tready)
        else $error("sequencer did not return to fetch after last pulse");

    // Instruction pulses leave the held data level alone
    a_instr_holds_level: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && !ctrl.shift_mode) |=> $stable(sdi_level_reg))
        else $error("instruction pulse changed the held data level");

    // Pulse counter never runs past the saturated maximum
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_PULSES)
        else $error("pulse counter out of range");

endmodule
